/* hw/rtl/cps_pkg.sv */
// Shared types and constants for the compacting pair set.
package cps_pkg;

   localparam int VAL_W  = 31;
   localparam int CMD_W  = 2;
   localparam int SLOT_W = 8;
   localparam int PCNT_W = 5;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_QUERY  = 2'd0;
   localparam cmd_type CMD_ADD    = 2'd1;
   localparam cmd_type CMD_REMOVE = 2'd2;
   localparam cmd_type CMD_READ   = 2'd3;

   typedef struct packed {
      cmd_type             cmd;
      logic [VAL_W-1:0]    first_value;
      logic [VAL_W-1:0]    second_value;
      logic [SLOT_W-1:0]   slot_index;
   } req_type;

   typedef struct packed {
      logic                success;
      logic [VAL_W-1:0]    read_first;
      logic [VAL_W-1:0]    read_second;
      logic [PCNT_W-1:0]   pair_count;
   } rsp_type;

   typedef struct packed {
      logic [VAL_W-1:0]    first_value;
      logic [VAL_W-1:0]    second_value;
   } pair_type;

   // sequencer -> scan unit
   typedef struct packed {
      logic clear;
      logic advance;
   } scan_ctl_type;

   // scan unit -> sequencer
   typedef struct packed {
      logic hit;      // entry read from the store equals the key
      logic at_end;   // pointer has reached the pair count
      logic last;     // pointer is on the last occupied slot
   } scan_sts_type;

endpackage

/* hw/rtl/cps_store.sv */
// Pair storage: one write port and one registered read port.
module cps_store
   import cps_pkg::*;
#(
   parameter int PAIR_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(PAIR_SLOTS)-1:0] wr_addr,
   input  pair_type                      wr_data,
   input  logic [$clog2(PAIR_SLOTS)-1:0] rd_addr,
   output pair_type                      rd_data
);

   pair_type slots_ff [PAIR_SLOTS];
   pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= slots_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/cps_scan.sv */
// Slot pointer for search and compaction, and the shared pair comparator used for search.
module cps_scan
   import cps_pkg::*;
#(
   parameter int PAIR_SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  scan_ctl_type                    ctl,
   input  pair_type                        key,
   input  pair_type                        entry,
   input  logic [$clog2(PAIR_SLOTS+1)-1:0] count,
   output logic [$clog2(PAIR_SLOTS+1)-1:0] slot,
   output scan_sts_type                    sts
);

   localparam int CNT_W = $clog2(PAIR_SLOTS + 1);

   logic [CNT_W-1:0] slot_ff;
   logic [CNT_W-1:0] slot_in;
   logic [CNT_W:0]   slot_next;

   assign slot_next = {1'b0, slot_ff} + 1'b1;

   always_comb begin
      slot_in = slot_ff;
      if (ctl.clear) begin
         slot_in = '0;
      end else if (ctl.advance) begin
         slot_in = slot_next[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign sts.hit    = (entry == key);
   assign sts.at_end = (slot_ff == count);
   assign sts.last   = (slot_next == {1'b0, count});
   assign slot       = slot_ff;

endmodule

/* hw/rtl/compacting_pair_set.sv */
// Top level: command sequencer and pair count for the compacting pair set.
//
//   channel | ports                     | handshake
//   --------+---------------------------+-------------------------------------
//   request | start, busy, req_item     | taken when start && !busy
//   result  | rsp_valid, rsp_item       | one-cycle strobe, no backpressure
//
// Query/add/remove scan the occupied slots one at a time through the single
// read port and one comparator, each slot through S_SCAN then S_CMP. A miss is
// strobed from S_SCAN at the pair count, a query or add hit from S_CMP; a remove
// hit pulls each later pair down through S_SHIFT and S_MOVE, strobed from S_SHIFT.
// Read of an occupied slot: S_FETCH then S_READ_OUT; out of range: answered from idle.
// Synchronous reset empties the set; the store itself is not cleared.
// busy drops on the cycle the result is strobed, so a new command may follow.
module compacting_pair_set
   import cps_pkg::*;
#(
   parameter int PAIR_SLOTS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int IDX_W = $clog2(PAIR_SLOTS);
   localparam int CNT_W = $clog2(PAIR_SLOTS + 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_CMP      = 3'd2;
   localparam logic [2:0] S_SHIFT    = 3'd3;
   localparam logic [2:0] S_MOVE     = 3'd4;
   localparam logic [2:0] S_FETCH    = 3'd5;
   localparam logic [2:0] S_READ_OUT = 3'd6;

   logic [2:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             started_ff;

   scan_ctl_type     ctl;
   scan_sts_type     sts;
   logic [CNT_W-1:0] slot;
   logic [CNT_W-1:0] slot_inc;
   pair_type         key;
   pair_type         rd_data;
   pair_type         wr_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   logic [CNT_W+4:0] pcnt_ext;
   logic             accept;
   logic             read_in_range;

   assign accept   = start && !busy;
   assign key      = '{first_value: req_ff.first_value, second_value: req_ff.second_value};
   assign slot_inc = slot + 1'b1;
   assign read_in_range =
      ({{CNT_W{1'b0}}, req_item.slot_index} < {8'd0, count_ff});

   cps_store #(.PAIR_SLOTS(PAIR_SLOTS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cps_scan #(.PAIR_SLOTS(PAIR_SLOTS)) u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .key   (key),
      .entry (rd_data),
      .count (count_ff),
      .slot  (slot),
      .sts   (sts)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl          = '0;
      wr_en        = 1'b0;
      wr_addr      = slot[IDX_W-1:0];
      wr_data      = rd_data;
      rd_addr      = slot[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in    = req_item;
               ctl.clear = 1'b1;
               if (req_item.cmd == CMD_READ) begin
                  if (read_in_range) begin
                     state_in = S_FETCH;
                  end else begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.success     = 1'b0;
                     rsp_in.read_first  = '0;
                     rsp_in.read_second = '0;
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (sts.at_end) begin
               // no match anywhere: only an add with room left succeeds
               rsp_valid_in       = 1'b1;
               rsp_in.read_first  = '0;
               rsp_in.read_second = '0;
               rsp_in.success     = 1'b0;
               state_in           = S_IDLE;
               if (req_ff.cmd == CMD_ADD && count_ff < CNT_W'(PAIR_SLOTS)) begin
                  wr_en          = 1'b1;
                  wr_addr        = count_ff[IDX_W-1:0];
                  wr_data        = key;
                  count_in       = count_ff + 1'b1;
                  rsp_in.success = 1'b1;
               end
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.hit) begin
               rsp_in.read_first  = '0;
               rsp_in.read_second = '0;
               case (req_ff.cmd)
                  CMD_QUERY: begin
                     rsp_valid_in   = 1'b1;
                     rsp_in.success = 1'b1;
                     state_in       = S_IDLE;
                  end
                  CMD_REMOVE: begin
                     state_in = S_SHIFT;
                  end
                  default: begin
                     // duplicate add
                     rsp_valid_in   = 1'b1;
                     rsp_in.success = 1'b0;
                     state_in       = S_IDLE;
                  end
               endcase
            end else begin
               ctl.advance = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SHIFT: begin
            if (sts.last) begin
               count_in           = count_ff - 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_in.success     = 1'b1;
               rsp_in.read_first  = '0;
               rsp_in.read_second = '0;
               state_in           = S_IDLE;
            end else begin
               rd_addr  = slot_inc[IDX_W-1:0];
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            // pull the next pair down into the current slot
            wr_en       = 1'b1;
            ctl.advance = 1'b1;
            state_in    = S_SHIFT;
         end
         S_FETCH: begin
            rd_addr  = req_ff.slot_index[IDX_W-1:0];
            state_in = S_READ_OUT;
         end
         S_READ_OUT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.success     = 1'b1;
            rsp_in.read_first  = rd_data.first_value;
            rsp_in.read_second = rd_data.second_value;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      pcnt_ext = {5'd0, count_in};
      if (rsp_valid_in) begin
         rsp_in.pair_count = pcnt_ext[PCNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // every transaction ends back in idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("result strobed while sequencer busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(PAIR_SLOTS))
      else $error("pair count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      started_ff && !$stable(count_ff) |->
         (count_ff == $past(count_ff) + 1'b1) || (count_ff == $past(count_ff) - 1'b1))
      else $error("pair count moved by more than one");

   a_count_with_rsp: assert property (@(posedge clock) disable iff (reset)
      started_ff && !$stable(count_ff) |-> rsp_valid_ff)
      else $error("pair count changed without a result");

   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> busy)
      else $error("store written while idle");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the compacting pair set: random command traffic against a predictor.
`timescale 1ns / 1ps

module testbench
   import cps_pkg::*;
;

   localparam int PAIR_SLOTS  = 16;
   localparam int RANDOM_CMDS = 1700;

   typedef enum int { PHASE_FILL, PHASE_DRAIN, PHASE_MIXED } phase_kind_type;

   typedef struct packed {
      logic    wait_for_drain;
      req_type item;
   } queued_cmd_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   queued_cmd_type cmd_queue[$];
   rsp_type        predicted_rsp_q[$];

   // predictor copy of the set
   pair_type set_slots[PAIR_SLOTS];
   int       held_pairs = 0;

   int error_count = 0;
   int gap_left = 0;
   int burst_left = 0;

   logic [VAL_W-1:0] pool_firsts[6];
   logic [VAL_W-1:0] pool_seconds[6];

   compacting_pair_set #(
      .PAIR_SLOTS(PAIR_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   always #4 clock = ~clock;

   // Apply one command to the predictor and return the response it should produce.
   function automatic rsp_type apply_command(req_type r);
      rsp_type res;
      int      hit_at;
      int      k;
      res = '0;
      hit_at = -1;
      for (k = 0; k < held_pairs; k++) begin
         if (hit_at < 0 && set_slots[k].first_value == r.first_value
               && set_slots[k].second_value == r.second_value) begin
            hit_at = k;
         end
      end
      case (r.cmd)
         CMD_QUERY: begin
            res.success = (hit_at >= 0);
         end
         CMD_ADD: begin
            if (hit_at < 0 && held_pairs < PAIR_SLOTS) begin
               set_slots[held_pairs].first_value  = r.first_value;
               set_slots[held_pairs].second_value = r.second_value;
               held_pairs++;
               res.success = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (hit_at >= 0) begin
               for (k = hit_at; k + 1 < held_pairs; k++) begin
                  set_slots[k] = set_slots[k + 1];
               end
               held_pairs--;
               res.success = 1'b1;
            end
         end
         default: begin
            if (int'(r.slot_index) < held_pairs) begin
               res.read_first  = set_slots[r.slot_index].first_value;
               res.read_second = set_slots[r.slot_index].second_value;
               res.success     = 1'b1;
            end
         end
      endcase
      res.pair_count = PCNT_W'(held_pairs);
      return res;
   endfunction

   task automatic queue_cmd(cmd_type c, logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                            logic [SLOT_W-1:0] idx, logic hold);
      queued_cmd_type e;
      e.wait_for_drain    = hold;
      e.item.cmd          = c;
      e.item.first_value  = a;
      e.item.second_value = b;
      e.item.slot_index   = idx;
      cmd_queue.push_back(e);
   endtask

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return VAL_W'($urandom_range(0, 15));
         default: return VAL_W'($urandom());
      endcase
   endfunction

   function automatic logic [SLOT_W-1:0] rand_slot();
      if ($urandom_range(0, 9) < 7)
         return SLOT_W'($urandom_range(0, PAIR_SLOTS + 1));
      return SLOT_W'($urandom_range(0, 255));
   endfunction

   function automatic cmd_type choose_cmd(phase_kind_type kind);
      int r;
      r = $urandom_range(0, 99);
      case (kind)
         PHASE_FILL: begin
            if (r < 60) return CMD_ADD;
            if (r < 75) return CMD_QUERY;
            if (r < 85) return CMD_REMOVE;
            return CMD_READ;
         end
         PHASE_DRAIN: begin
            if (r < 55) return CMD_REMOVE;
            if (r < 65) return CMD_ADD;
            if (r < 80) return CMD_QUERY;
            return CMD_READ;
         end
         default: return cmd_type'(r % 4);
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= 10)
         $display("%0t ERROR: %s", $realtime, msg);
   endtask

   // Driver: bursts of commands with random gaps; start is held until busy lets it in.
   always @(posedge clock) begin : driver
      logic go;
      if (reset) begin
         start    <= 1'b0;
         req_item <= '0;
      end else begin
         go = start;
         if (start && !busy) begin
            predicted_rsp_q.push_back(apply_command(req_item));
            void'(cmd_queue.pop_front());
            go = 1'b0;
            if (burst_left == 0) begin
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               burst_left = $urandom_range(0, 20);
            end else begin
               burst_left--;
            end
         end
         if (!go) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_queue.size() > 0 && !(cmd_queue[0].wait_for_drain
                  && predicted_rsp_q.size() > 0)) begin
               go = 1'b1;
               req_item <= cmd_queue[0].item;
            end
         end
         start <= go;
      end
   end

   // Monitor: every strobed response is matched against the oldest prediction.
   always @(posedge clock) begin : monitor
      rsp_type exp;
      string   bad;
      if (!reset && rsp_valid) begin
         if (predicted_rsp_q.size() == 0) begin
            report_mismatch($sformatf("response with no transaction pending: %p", rsp_item));
         end else begin
            exp = predicted_rsp_q.pop_front();
            bad = "";
            if (rsp_item.success !== exp.success) bad = {bad, " success"};
            if (rsp_item.read_first !== exp.read_first) bad = {bad, " read_first"};
            if (rsp_item.read_second !== exp.read_second) bad = {bad, " read_second"};
            if (rsp_item.pair_count !== exp.pair_count) bad = {bad, " pair_count"};
            if (bad != "")
               report_mismatch($sformatf("field(s)%s differ: expected %p, got %p",
                                         bad, exp, rsp_item));
         end
      end
   end

   initial begin
      logic [VAL_W-1:0] zero_v;
      logic [VAL_W-1:0] max_v;
      phase_kind_type   kind;
      int               phase_len;
      int               made;
      int               i;
      logic             hold;
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;

      zero_v = '0;
      max_v  = '1;

      // directed: empty set, extremes, duplicate add, partial matches, compaction
      queue_cmd(CMD_READ,   rand_value(), rand_value(), 8'd0,   1'b0);
      queue_cmd(CMD_READ,   rand_value(), rand_value(), 8'd255, 1'b0);
      queue_cmd(CMD_QUERY,  zero_v, zero_v, rand_slot(), 1'b0);
      queue_cmd(CMD_REMOVE, zero_v, zero_v, rand_slot(), 1'b0);
      queue_cmd(CMD_ADD,    zero_v, zero_v, rand_slot(), 1'b0);
      queue_cmd(CMD_ADD,    max_v,  max_v,  rand_slot(), 1'b0);
      queue_cmd(CMD_ADD,    zero_v, zero_v, rand_slot(), 1'b0);
      queue_cmd(CMD_ADD,    zero_v, max_v,  rand_slot(), 1'b0);
      queue_cmd(CMD_ADD,    max_v,  zero_v, rand_slot(), 1'b0);
      queue_cmd(CMD_QUERY,  max_v,  zero_v, rand_slot(), 1'b0);
      queue_cmd(CMD_QUERY,  zero_v, 31'd1,  rand_slot(), 1'b0);
      queue_cmd(CMD_QUERY,  31'd1,  zero_v, rand_slot(), 1'b0);
      for (i = 0; i < 5; i++)
         queue_cmd(CMD_READ, rand_value(), rand_value(), SLOT_W'(i), 1'b0);
      queue_cmd(CMD_REMOVE, zero_v, max_v,  rand_slot(), 1'b0);
      queue_cmd(CMD_READ,   rand_value(), rand_value(), 8'd1, 1'b0);
      queue_cmd(CMD_READ,   rand_value(), rand_value(), 8'd3, 1'b0);
      queue_cmd(CMD_REMOVE, zero_v, zero_v, rand_slot(), 1'b0);
      queue_cmd(CMD_REMOVE, max_v,  zero_v, rand_slot(), 1'b0);
      queue_cmd(CMD_QUERY,  zero_v, max_v,  rand_slot(), 1'b0);
      queue_cmd(CMD_READ,   rand_value(), rand_value(), 8'd0, 1'b0);

      // random phases over a small value pool so hits, partial matches and a full set occur
      made = 0;
      kind = PHASE_FILL;
      while (made < RANDOM_CMDS) begin
         for (i = 0; i < 6; i++) begin
            pool_firsts[i]  = rand_value();
            pool_seconds[i] = rand_value();
         end
         phase_len = $urandom_range(30, 90);
         hold = (made == 0) || ($urandom_range(0, 2) == 0);
         for (i = 0; i < phase_len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               a = VAL_W'($urandom());
               b = VAL_W'($urandom());
            end else begin
               a = pool_firsts[$urandom_range(0, 5)];
               b = pool_seconds[$urandom_range(0, 5)];
            end
            queue_cmd(choose_cmd(kind), a, b, rand_slot(), hold && (i == 0));
         end
         made += phase_len;
         kind = phase_kind_type'($urandom_range(0, 2));
      end

      @(negedge reset);
      while (cmd_queue.size() != 0 || predicted_rsp_q.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
